FILE: hdl/weighted_table_route_select_assert.svh
// weighted_table_route_select_assert.svh: assertion macros for the route selector
// used by weighted_table_route_select.sv; expects clock and reset in scope
`ifndef WEIGHTED_TABLE_ROUTE_SELECT_ASSERT_SVH
`define WEIGHTED_TABLE_ROUTE_SELECT_ASSERT_SVH

// property that holds in the same cycle, checked outside reset
`define WTRS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("route select assertion failed");

// antecedent in one cycle implies consequent in the next
`define WTRS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("route select assertion failed");

`endif

FILE: hdl/wtrs_pkg.sv
// wtrs_pkg.sv: sizes, command codes and sequencer states of the route selector
// no dependencies; imported by weighted_table_route_select.sv
`timescale 1ns / 1ps

package wtrs_pkg;

   // table geometry
   localparam int NUM_VNETS = 4;
   localparam int NUM_LINKS = 8;
   localparam int DEST_BITS = 32;

   // derived widths
   localparam int LINK_W   = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
   localparam int CNT_W    = $clog2(NUM_LINKS + 1);
   localparam int ENTRIES  = NUM_VNETS * NUM_LINKS;
   localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RND_W    = 16;
   localparam int MOD_STEPS = RND_W / 2;
   localparam int STEP_MAX = (NUM_LINKS > MOD_STEPS) ? NUM_LINKS : MOD_STEPS;
   localparam int STEP_W   = $clog2(STEP_MAX + 1);

   // port field widths
   localparam int CMD_W    = 2;
   localparam int VNET_W   = 2;
   localparam int PORT_LINK_W = 3;
   localparam int MASK_W   = 32;
   localparam int WEIGHT_W = 8;
   localparam int TIED_W   = 4;
   localparam int ORD_W    = 4;

   localparam logic [RND_W-1:0] LFSR_SEED = 16'hACE1;

   // request commands
   localparam logic [CMD_W-1:0] CMD_LOOKUP    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WR_MASK   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WR_WEIGHT = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_MOD,
      ST_SELECT
   } state_type;

endpackage

FILE: hdl/weighted_table_route_select.sv
// weighted_table_route_select.sv: router output-link selector by minimum weight with tie break
// depends on wtrs_pkg and weighted_table_route_select_assert.svh
`timescale 1ns / 1ps
//
// Usage
//   Request channel: drive req_* and raise start; a request is taken at a clock
//   edge with start high and busy low. Commands: lookup, write route mask
//   (per vnet and link), write link weight.
//   Result channel: one result per request, shown on rsp_* for exactly one cycle
//   with rsp_strobe high. The receiver cannot stall it.
//   Writes answer in the cycle after the request and leave busy low.
//   A lookup with a valid vnet holds busy high while a small sequencer walks the
//   route-mask memory once (one link per cycle through a registered read, then a
//   drain and a decide step); if any link matched, it then runs a 2-bit-per-cycle
//   remainder of the 16-bit LFSR by the tie count (skipped on ordered vnets),
//   then walks the tied links to the chosen one.
//   Config: APB register 0 at byte address 0 is ordered_vnets (4 bits).
//   Reset clears the mask valid bits, the weights and the register and loads the
//   LFSR seed at once; there is no clearing pass.

`include "weighted_table_route_select_assert.svh"

module weighted_table_route_select
   import wtrs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  logic [CMD_W-1:0]       req_command,
   input  logic [VNET_W-1:0]      req_vnet,
   input  logic [PORT_LINK_W-1:0] req_link,
   input  logic [MASK_W-1:0]      req_mask,
   input  logic [WEIGHT_W-1:0]    req_weight,
   // result channel
   output logic                   rsp_strobe,
   output logic [PORT_LINK_W-1:0] rsp_out_link,
   output logic                   rsp_no_route,
   output logic [TIED_W-1:0]      rsp_tied_count,
   // configuration port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   // one remainder step: shift in a bit, subtract divisor when it fits
   function automatic logic [CNT_W-1:0] mod_step(input logic [CNT_W-1:0] rem,
                                                 input logic b,
                                                 input logic [CNT_W-1:0] div);
      logic [CNT_W:0] sh;
      sh = {rem, b};
      if (sh >= {1'b0, div}) sh = sh - {1'b0, div};
      return sh[CNT_W-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [DEST_BITS-1:0] dest_ff, dest_in;
   logic [VNET_W-1:0]    vnet_ff, vnet_in;
   logic [RND_W-1:0]     rnd_ff, rnd_in;
   logic [RND_W-1:0]     lfsr_ff, lfsr_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [LINK_W-1:0]    rd_link_ff, rd_link_in;
   logic [NUM_LINKS-1:0] cand_ff, cand_in;
   logic                 have_min_ff, have_min_in;
   logic [WEIGHT_W-1:0]  min_ff, min_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     seen_ff, seen_in;
   logic [ORD_W-1:0]     ordered_ff;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [PORT_LINK_W-1:0] rsp_link_ff, rsp_link_in;
   logic                   rsp_nr_ff, rsp_nr_in;
   logic [TIED_W-1:0]      rsp_tied_ff, rsp_tied_in;

   // link weights and route-mask memory
   logic [WEIGHT_W-1:0]  weights_ff [NUM_LINKS];
   logic [DEST_BITS-1:0] route_mem [ENTRIES];
   logic [ENTRIES-1:0]   mask_vld_ff;
   logic [DEST_BITS-1:0] rd_data_ff;
   logic                 rd_ent_vld_ff;

   logic                 accept;
   logic                 vnet_ok;
   logic                 link_ok;
   logic                 mem_we;
   logic                 wt_we;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ADDR_W-1:0]    rd_addr;
   logic [63:0]          mask_ext;
   logic [DEST_BITS-1:0] mask_dest;
   logic                 scan_hit;
   logic [WEIGHT_W-1:0]  scan_wt;
   logic [NUM_LINKS-1:0] tie_vec;
   logic [LINK_W-1:0]    sel_idx;
   logic [TIED_W-1:0]    tied_sat;
   logic                 lfsr_bit;
   logic                 cfg_we;

   // request decode
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign vnet_ok   = (32'(req_vnet) < NUM_VNETS);
   assign link_ok   = (32'(req_link) < NUM_LINKS);
   assign mask_ext  = {32'd0, req_mask};
   assign mask_dest = mask_ext[DEST_BITS-1:0];
   assign wr_addr   = ADDR_W'(32'(req_vnet) * NUM_LINKS + 32'(req_link));
   assign rd_addr   = ADDR_W'(32'(vnet_ff) * NUM_LINKS + 32'(cnt_ff[LINK_W-1:0]));
   assign lfsr_bit  = lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5];

   // scan datapath: candidate test of the entry read last cycle
   assign scan_hit = rd_ent_vld_ff && (|(rd_data_ff & dest_ff));
   assign scan_wt  = weights_ff[rd_link_ff];

   // tied links: candidates at the minimum weight
   always_comb begin
      for (int l = 0; l < NUM_LINKS; l++) begin
         tie_vec[l] = cand_ff[l] && (weights_ff[l] == min_ff);
      end
   end

   assign sel_idx  = cnt_ff[LINK_W-1:0];
   assign tied_sat = (32'(count_ff) > 15) ? 4'd15 : TIED_W'(count_ff);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer: next state and datapath next values
   always_comb begin
      state_in      = state_ff;
      dest_in       = dest_ff;
      vnet_in       = vnet_ff;
      rnd_in        = rnd_ff;
      lfsr_in       = lfsr_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = 1'b0;
      rd_link_in    = rd_link_ff;
      cand_in       = cand_ff;
      have_min_in   = have_min_ff;
      min_in        = min_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      seen_in       = seen_ff;
      rsp_strobe_in = 1'b0;
      rsp_link_in   = rsp_link_ff;
      rsp_nr_in     = rsp_nr_ff;
      rsp_tied_in   = rsp_tied_ff;
      mem_we        = 1'b0;
      wt_we         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_link_in = '0;
               rsp_nr_in   = 1'b0;
               rsp_tied_in = '0;
               case (req_command)
                  CMD_LOOKUP: begin
                     lfsr_in     = {lfsr_bit, lfsr_ff[RND_W-1:1]};
                     rnd_in      = lfsr_ff;
                     dest_in     = mask_dest;
                     vnet_in     = req_vnet;
                     cnt_in      = '0;
                     cand_in     = '0;
                     have_min_in = 1'b0;
                     count_in    = '0;
                     if (vnet_ok) begin
                        state_in = ST_SCAN;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_nr_in     = 1'b1;
                     end
                  end
                  CMD_WR_MASK: begin
                     mem_we        = vnet_ok && link_ok;
                     rsp_strobe_in = 1'b1;
                  end
                  CMD_WR_WEIGHT: begin
                     wt_we         = link_ok;
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // issue one memory read per cycle
            if (32'(cnt_ff) < NUM_LINKS) begin
               rd_vld_in  = 1'b1;
               rd_link_in = cnt_ff[LINK_W-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end
            // running minimum and tie count over returned entries
            if (rd_vld_ff && scan_hit) begin
               cand_in[rd_link_ff] = 1'b1;
               if (!have_min_ff || (scan_wt < min_ff)) begin
                  have_min_in = 1'b1;
                  min_in      = scan_wt;
                  count_in    = CNT_W'(1);
               end else if (scan_wt == min_ff) begin
                  count_in = count_ff + 1'b1;
               end
            end
            if ((32'(cnt_ff) == NUM_LINKS) && !rd_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            rem_in  = '0;
            seen_in = '0;
            cnt_in  = '0;
            if (count_ff == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_link_in   = '0;
               rsp_nr_in     = 1'b1;
               rsp_tied_in   = '0;
               state_in      = ST_IDLE;
            end else if (ordered_ff[vnet_ff]) begin
               state_in = ST_SELECT;
            end else begin
               state_in = ST_MOD;
            end
         end

         ST_MOD: begin
            // two remainder bits per cycle, msb first
            rem_in = mod_step(mod_step(rem_ff, rnd_ff[RND_W-1], count_ff),
                              rnd_ff[RND_W-2], count_ff);
            rnd_in = {rnd_ff[RND_W-3:0], 2'b00};
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == MOD_STEPS - 1) begin
               cnt_in   = '0;
               seen_in  = '0;
               state_in = ST_SELECT;
            end
         end

         ST_SELECT: begin
            // walk tied links until the picked position
            cnt_in = cnt_ff + 1'b1;
            if (tie_vec[sel_idx]) begin
               if (seen_ff == rem_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_link_in   = PORT_LINK_W'(sel_idx);
                  rsp_nr_in     = 1'b0;
                  rsp_tied_in   = tied_sat;
                  state_in      = ST_IDLE;
               end else begin
                  seen_in = seen_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff       <= LFSR_SEED;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         lfsr_ff       <= lfsr_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dest_ff     <= dest_in;
      vnet_ff     <= vnet_in;
      rnd_ff      <= rnd_in;
      cnt_ff      <= cnt_in;
      rd_link_ff  <= rd_link_in;
      cand_ff     <= cand_in;
      have_min_ff <= have_min_in;
      min_ff      <= min_in;
      count_ff    <= count_in;
      rem_ff      <= rem_in;
      seen_ff     <= seen_in;
      rsp_link_ff <= rsp_link_in;
      rsp_nr_ff   <= rsp_nr_in;
      rsp_tied_ff <= rsp_tied_in;
   end

   // link weight table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_LINKS; l++) begin
            weights_ff[l] <= '0;
         end
      end else if (wt_we) begin
         weights_ff[LINK_W'(req_link)] <= req_weight;
      end
   end

   // route-mask memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         route_mem[wr_addr] <= mask_dest;
      end
      rd_data_ff <= route_mem[rd_addr];
   end

   // per-entry valid bits; an unwritten entry counts as an empty mask
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_vld_ff   <= '0;
         rd_ent_vld_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            mask_vld_ff[wr_addr] <= 1'b1;
         end
         rd_ent_vld_ff <= mask_vld_ff[rd_addr];
      end
   end

   // configuration register
   assign cfg_we = psel && penable && pwrite && pready && !paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         ordered_ff <= '0;
      end else if (cfg_we) begin
         ordered_ff <= pwdata[ORD_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {{(32 - ORD_W){1'b0}}, ordered_ff};

   // result ports
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_out_link   = rsp_link_ff;
   assign rsp_no_route   = rsp_nr_ff;
   assign rsp_tied_count = rsp_tied_ff;

   // checks
   `WTRS_ASSERT(a_strobe_not_busy, rsp_strobe |-> !busy)
   `WTRS_ASSERT_NEXT(a_write_answers, start && !busy && (req_command != CMD_LOOKUP), rsp_strobe)
   `WTRS_ASSERT(a_no_route_zero, rsp_strobe && rsp_no_route |-> (rsp_tied_count == '0))
   `WTRS_ASSERT(a_pick_in_range, (state_ff == ST_SELECT) |-> (rem_ff < count_ff))

endmodule
